>>> rtl/bitplane_scroll_fill_macros.svh
// Assertion macros for the bitplane scroll fill block.
// No dependencies; included by the modules that assert.
`ifndef BITPLANE_SCROLL_FILL_MACROS_SVH
`define BITPLANE_SCROLL_FILL_MACROS_SVH
`ifndef SYNTHESIS
`define BSF_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("bsf check failed");
`define BSF_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("bsf check failed");
`else
`define BSF_ASSERT(label, clk, rst_n, prop)
`define BSF_ASSERT_NR(label, clk, prop)
`endif
`endif

>>> rtl/bsf_pkg.sv
// Package for the bitplane scroll fill block: command codes, controller
// states and the command/status structs. No dependencies.
package bsf_pkg;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_SCROLL = 2'd2;

  localparam int unsigned REG_TALL   = 0;
  localparam int unsigned REG_UPPER  = 1;
  localparam int unsigned REG_MONO   = 2;
  localparam int unsigned REG_MPLANE = 3;
  localparam int unsigned REG_FOUR   = 4;
  localparam int unsigned REG_BG     = 5;

  typedef enum logic [6:0] {
    ST_CLEAR  = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_RDWAIT = 7'b0000100,
    ST_COPY   = 7'b0001000,
    ST_FILL   = 7'b0010000,
    ST_NEXT   = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic clr_step;   // clearing pass: write zero, advance
    logic host_wr;    // host byte write
    logic host_rd;    // host byte read
    logic nop;        // unused command: zero result, store untouched
    logic cap;        // capture scroll parameters
    logic plane_init; // pick first plane, set its fill byte
    logic copy_step;  // copy one byte of plane into scratch
    logic fill_step;  // write one destination byte
    logic idx_reset;  // reset index counter
    logic plane_next; // advance to next plane
    logic res_load;   // load result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic clr_done;
    logic illegal;
    logic copy_last;
    logic fill_last;
    logic plane_none;  // no plane left to do
  } sts_t;

endpackage

>>> rtl/bsf_ctrl.sv
// Controller state machine of the bitplane scroll fill block.
// Depends on bsf_pkg and bitplane_scroll_fill_macros.svh.
`include "bitplane_scroll_fill_macros.svh"
module bsf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_cmd,
  output logic           out_valid,
  input  logic           out_stall,
  input  bsf_pkg::sts_t  sts,
  output bsf_pkg::cmd_t  cmd
);

  bsf_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic acc;
  logic res_free;

  assign out_valid = out_valid_r;
  // The result register is free when empty or being taken this cycle.
  assign res_free  = !out_valid_r || !out_stall;
  assign in_stall  = !(state_r == bsf_pkg::ST_IDLE) || !res_free;
  assign acc       = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      bsf_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_nxt = bsf_pkg::ST_IDLE;
      end
      bsf_pkg::ST_IDLE: begin
        if (acc) begin
          priority if (in_cmd == bsf_pkg::CMD_SCROLL) begin
            cmd.cap   = 1'b1;
            state_nxt = bsf_pkg::ST_RDWAIT;
          end else if (in_cmd == bsf_pkg::CMD_READ) begin
            cmd.host_rd = 1'b1;
            state_nxt   = bsf_pkg::ST_DONE;
          end else if (in_cmd == bsf_pkg::CMD_WRITE) begin
            cmd.host_wr   = 1'b1;
            cmd.res_load  = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.nop       = 1'b1;
            cmd.res_load  = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      bsf_pkg::ST_RDWAIT: begin
        if (sts.illegal) begin
          state_nxt = bsf_pkg::ST_DONE;
        end else begin
          cmd.plane_init = 1'b1;
          state_nxt      = bsf_pkg::ST_NEXT;
        end
      end
      bsf_pkg::ST_NEXT: begin
        if (sts.plane_none) begin
          state_nxt = bsf_pkg::ST_DONE;
        end else begin
          cmd.idx_reset = 1'b1;
          state_nxt     = bsf_pkg::ST_COPY;
        end
      end
      bsf_pkg::ST_COPY: begin
        cmd.copy_step = 1'b1;
        if (sts.copy_last) begin
          cmd.idx_reset = 1'b1;
          state_nxt     = bsf_pkg::ST_FILL;
        end
      end
      bsf_pkg::ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          cmd.plane_next = 1'b1;
          state_nxt      = bsf_pkg::ST_NEXT;
        end
      end
      bsf_pkg::ST_DONE: begin
        if (res_free) begin
          cmd.res_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bsf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bsf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsf_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `BSF_ASSERT(a_onehot, clk, rst_n, $onehot(state_r))
  `BSF_ASSERT(a_no_acc_busy, clk, rst_n, (state_r != bsf_pkg::ST_IDLE) |-> in_stall)
  `BSF_ASSERT(a_hold_result, clk, rst_n, (out_valid_r && out_stall) |=> out_valid_r)
  `BSF_ASSERT(a_load_free, clk, rst_n, cmd.res_load |-> res_free)

endmodule

>>> rtl/bsf_dpath.sv
// Datapath of the bitplane scroll fill block: video store, scratch copy,
// counters, scroll address generation and result register. Depends on bsf_pkg.
module bsf_dpath #(
  parameter int unsigned LINE_BYTES  = 80,
  parameter int unsigned MAX_LINES   = 400,
  parameter int unsigned PLANES      = 4,
  parameter int unsigned PAGE_OFFSET = 16000
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bsf_pkg::cmd_t cmd,
  output bsf_pkg::sts_t sts,
  input  logic [1:0]    in_plane,
  input  logic [14:0]   in_byte_addr,
  input  logic [7:0]    in_write_data,
  input  logic signed [15:0] in_shift_y,
  input  logic signed [15:0] in_shift_x,
  input  logic [7:0]    in_clear_mode,
  input  logic          tall_screen,
  input  logic          upper_page,
  input  logic          mono_mode,
  input  logic [1:0]    mono_plane,
  input  logic          four_planes,
  input  logic [3:0]    background_color,
  output logic [7:0]    out_read_data,
  output logic          out_status
);

  localparam int unsigned PLANE_BYTES = MAX_LINES * LINE_BYTES;
  localparam int unsigned STORE_BYTES = PLANES * PLANE_BYTES;
  localparam int unsigned AW  = $clog2(STORE_BYTES);
  localparam int unsigned PW  = $clog2(PLANE_BYTES + 1);
  localparam int unsigned SW  = $clog2(PLANE_BYTES);
  localparam int unsigned LW  = $clog2(MAX_LINES + 1);
  localparam int unsigned BW  = $clog2(LINE_BYTES + 1);
  localparam int unsigned PAGE_MOD = PAGE_OFFSET % PLANE_BYTES;
  localparam int unsigned DXMAX = LINE_BYTES * 8 - 1;
  localparam logic signed [16:0] DXMAX_S = 17'(DXMAX);

  logic [7:0] store_m [STORE_BYTES];
  logic [7:0] scratch_m [PLANE_BYTES];

  // Clearing pass.
  logic [AW-1:0] clr_r;
  // Scroll parameters.
  logic signed [16:0] dy_r;
  logic signed [13:0] dxb_r;
  logic [7:0] clr_mode_r;
  logic [3:0] mask_r;
  logic [1:0] pl_r;
  logic pl_none_r;
  logic [LW-1:0] height_r;
  logic [PW-1:0] count_r;
  logic [PW-1:0] pageoff_r;
  // Walk counters.
  logic [PW-1:0] idx_r;
  logic [PW-1:0] src_a_r;  // (pageoff + idx) mod PLANE_BYTES
  logic [BW-1:0] b_r;
  logic signed [17:0] sy_r;  // y + dy
  logic [PW-1:0] srow_r;     // sy * LINE_BYTES when sy valid
  // Copy pipeline: read store, then write scratch.
  logic cp_v_r;
  logic [SW-1:0] cp_i_r;
  // Fill pipeline: read scratch, then write store.
  logic fl_v_r;
  logic fl_in_r;
  logic [AW-1:0] fl_dst_r;
  logic [7:0] fill_r;
  logic [7:0] fl_fill_r;
  logic [7:0] rd_q_r, sc_q_r;
  logic [7:0] res_data_r;
  logic res_stat_r;
  logic hrd_r;
  logic hok_r;
  logic illegal_r;

  logic [AW-1:0] plane_base;
  logic [AW-1:0] host_a;
  logic host_ok;
  logic signed [17:0] sb;
  logic src_in;
  logic [SW-1:0] sc_a;
  logic [PW-1:0] nxt_a;
  logic [2:0] pn;
  logic found;
  logic [1:0] pfound;
  logic [LW-1:0] height_c;
  logic signed [16:0] hgt_s;
  logic signed [16:0] dyc;
  logic signed [16:0] dxc;
  logic [3:0] mask_c;

  assign plane_base = AW'(pl_r) * AW'(PLANE_BYTES);
  assign host_ok = (32'(in_plane) < PLANES) && (32'(in_byte_addr) < PLANE_BYTES);
  assign host_a  = AW'(in_plane) * AW'(PLANE_BYTES) + AW'(in_byte_addr);

  assign height_c = tall_screen ? LW'(MAX_LINES) : LW'(MAX_LINES / 2);
  assign hgt_s = $signed(17'(height_c));
  assign dyc = 17'(in_shift_y);
  assign dxc = 17'(in_shift_x);
  assign mask_c = mono_mode ? (4'b0001 << mono_plane) : (four_planes ? 4'hf : 4'h7);

  // Next plane search over at most four planes, from pn upward.
  always_comb begin
    found  = 1'b0;
    pfound = '0;
    pn     = cmd.plane_init ? 3'd0 : (3'(pl_r) + 3'd1);
    for (int k = 3; k >= 0; k--) begin
      if (3'(k) >= pn && mask_r[k] && (k < int'(PLANES))) begin
        found  = 1'b1;
        pfound = 2'(k);
      end
    end
  end

  assign sb     = 18'(b_r) + 18'(dxb_r);
  assign src_in = (sy_r >= 0) && (sy_r < 18'(height_r)) && (sb >= 0)
                  && (sb < 18'(LINE_BYTES));
  assign sc_a   = SW'(srow_r + PW'(sb));
  assign nxt_a  = (src_a_r == PW'(PLANE_BYTES - 1)) ? '0 : src_a_r + 1'b1;

  assign sts.clr_done   = (clr_r == AW'(STORE_BYTES - 1));
  assign sts.illegal    = illegal_r;
  assign sts.copy_last  = (idx_r == count_r - 1'b1);
  assign sts.fill_last  = (idx_r == count_r - 1'b1);
  assign sts.plane_none = pl_none_r;

  // Legality check registered at capture, since mask and height are config.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      dy_r       <= dyc;
      // Truncate toward zero: add 7 before shifting a negative value.
      dxb_r      <= 14'((dxc + (dxc < 0 ? 17'sd7 : 17'sd0)) >>> 3);
      clr_mode_r <= in_clear_mode;
      height_r   <= height_c;
      count_r    <= PW'(height_c * LINE_BYTES);
      pageoff_r  <= upper_page ? PW'(PAGE_MOD) : '0;
      mask_r     <= mask_c;
      illegal_r  <= (in_clear_mode > 8'd1) || (dyc <= -hgt_s)
                    || (dyc >= hgt_s) || (dxc < -DXMAX_S)
                    || (dxc > DXMAX_S);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.plane_init || cmd.plane_next) begin
      pl_r      <= pfound;
      pl_none_r <= !found;
      fill_r    <= (clr_mode_r[0] && background_color[pfound]) ? 8'hff : 8'h00;
    end
    if (cmd.idx_reset) begin
      idx_r   <= '0;
      src_a_r <= pageoff_r;
      b_r     <= '0;
      sy_r    <= 18'(dy_r);
      srow_r  <= PW'(18'(dy_r) * 18'(LINE_BYTES));
    end else if (cmd.copy_step || cmd.fill_step) begin
      idx_r   <= idx_r + 1'b1;
      src_a_r <= nxt_a;
      if (b_r == BW'(LINE_BYTES - 1)) begin
        b_r    <= '0;
        sy_r   <= sy_r + 18'sd1;
        srow_r <= srow_r + PW'(LINE_BYTES);
      end else begin
        b_r <= b_r + 1'b1;
      end
    end
  end

  // Memory ports.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      cp_v_r <= 1'b0;
      fl_v_r <= 1'b0;
      hrd_r  <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      cp_v_r <= cmd.copy_step;
      fl_v_r <= cmd.fill_step;
      hrd_r  <= cmd.host_rd;
    end
  end

  always_ff @(posedge clk) begin
    cp_i_r    <= SW'(idx_r);
    fl_in_r   <= src_in;
    fl_dst_r  <= plane_base + AW'(src_a_r);
    // Hold the fill byte with its address; the plane may advance meanwhile.
    fl_fill_r <= fill_r;
    rd_q_r    <= store_m[cmd.host_rd ? host_a : plane_base + AW'(src_a_r)];
    // The last copied byte lands in scratch while the first fill reads it.
    sc_q_r    <= (cp_v_r && (cp_i_r == sc_a)) ? rd_q_r : scratch_m[sc_a];
    if (cmd.clr_step) begin
      store_m[clr_r] <= 8'h00;
    end else if (cmd.host_wr && host_ok) begin
      store_m[host_a] <= in_write_data;
    end else if (fl_v_r) begin
      store_m[fl_dst_r] <= fl_in_r ? sc_q_r : fl_fill_r;
    end
  end

  // Scratch written in the cycle after the store read.
  always_ff @(posedge clk) begin
    if (cp_v_r) scratch_m[cp_i_r] <= rd_q_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.host_rd) hok_r <= host_ok;
    if (cmd.res_load) begin
      res_data_r <= (hrd_r && hok_r) ? rd_q_r : 8'h00;
      res_stat_r <= hrd_r ? 1'b0 : ((cmd.host_wr || cmd.nop) ? 1'b0 : illegal_r);
    end
  end

  assign out_read_data = res_data_r;
  assign out_status    = res_stat_r;

endmodule

>>> rtl/bitplane_scroll_fill.sv
// Top level of the bitplane scroll fill block: configuration registers,
// controller and datapath. Depends on bsf_pkg, bsf_ctrl and bsf_dpath.
//
// Use: a planar video store of PLANES planes of MAX_LINES*LINE_BYTES bytes.
// Input words (in_valid/in_stall) carry a command: write byte, read byte or
// scroll. Every input word gives exactly one result word (out_valid/out_stall)
// with read_data and status; status is 1 for a scroll with illegal parameters.
// A write's result is registered on acceptance; a read's result passes the
// store read register, then waits in the done state for a free result register.
// A scroll copies each enabled plane byte by byte into a scratch memory, then
// writes it back shifted, one byte a cycle. An illegal scroll goes from the
// wait state straight to the done state. One word is in work at a time. After
// reset the store (STORE_BYTES bytes, 128000 by default) is swept to zero,
// during which no input word is accepted; configuration writes are taken at
// any time the block is idle. A stalled result is held in the output
// register; a new word is accepted once that register is free or being taken.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) are registered.
module bitplane_scroll_fill #(
  parameter int unsigned LINE_BYTES  = 80,
  parameter int unsigned MAX_LINES   = 400,
  parameter int unsigned PLANES      = 4,
  parameter int unsigned PAGE_OFFSET = 16000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [1:0]  in_plane,
  input  logic [14:0] in_byte_addr,
  input  logic [7:0]  in_write_data,
  input  logic signed [15:0] in_shift_y,
  input  logic signed [15:0] in_shift_x,
  input  logic [7:0]  in_clear_mode,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_status,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  bsf_pkg::cmd_t cmd;
  bsf_pkg::sts_t sts;

  logic tall_r, upper_r, mono_r, four_r;
  logic [1:0] mplane_r;
  logic [3:0] bg_r;

  // Hold configuration; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tall_r   <= 1'b0;
      upper_r  <= 1'b0;
      mono_r   <= 1'b0;
      mplane_r <= '0;
      four_r   <= 1'b0;
      bg_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        3'(bsf_pkg::REG_TALL):   tall_r   <= cfg_data[0];
        3'(bsf_pkg::REG_UPPER):  upper_r  <= cfg_data[0];
        3'(bsf_pkg::REG_MONO):   mono_r   <= cfg_data[0];
        3'(bsf_pkg::REG_MPLANE): mplane_r <= cfg_data[1:0];
        3'(bsf_pkg::REG_FOUR):   four_r   <= cfg_data[0];
        3'(bsf_pkg::REG_BG):     bg_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  bsf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd,
    .out_valid, .out_stall, .sts, .cmd
  );

  bsf_dpath #(
    .LINE_BYTES(LINE_BYTES), .MAX_LINES(MAX_LINES),
    .PLANES(PLANES), .PAGE_OFFSET(PAGE_OFFSET)
  ) u_dpath (
    .clk, .rst_n, .cmd, .sts,
    .in_plane, .in_byte_addr, .in_write_data,
    .in_shift_y, .in_shift_x, .in_clear_mode,
    .tall_screen(tall_r), .upper_page(upper_r), .mono_mode(mono_r),
    .mono_plane(mplane_r), .four_planes(four_r), .background_color(bg_r),
    .out_read_data, .out_status
  );

endmodule

>>> bench/tb_bitplane_scroll_fill.sv
// Self-checking bench for bitplane_scroll_fill: byte writes, reads and scroll
// blits against a behavioural copy of the planar store. Depends on bsf_pkg.
`timescale 1ns / 1ps

module tb_bitplane_scroll_fill;

  localparam int unsigned PLANE_SZ = 32000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_cmd;
  logic [1:0]  in_plane;
  logic [14:0] in_byte_addr;
  logic [7:0]  in_write_data;
  logic signed [15:0] in_shift_y;
  logic signed [15:0] in_shift_x;
  logic [7:0]  in_clear_mode;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_read_data;
  logic        out_status;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [3:0]  cfg_data;

  bitplane_scroll_fill dut (.*);

  typedef struct {
    logic [7:0] read_data;
    logic       status;
  } result_t;

  // Behavioural store, scroll scratch and register copies.
  logic [7:0] plane_mem [0:4*PLANE_SZ-1];
  logic [7:0] line_copy [0:PLANE_SZ-1];
  logic       m_tall, m_upper, m_mono, m_four;
  logic [1:0] m_mplane;
  logic [3:0] m_bg;

  result_t expected_q[$];
  int      errors;
  int      send_idle_pct;
  int      stall_pct;
  int      hold_off;
  int      legal_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Limit: far beyond the clearing sweep, every scroll and every stall.
  initial begin
    #16_000_000;
    $display("** bitplane_scroll_fill: FAILED **");
    $finish;
  end

  // Work out the scroll on the copy; return the status bit.
  function automatic logic scroll_store(int dy, int dx, int clr);
    int   h, dxb, po, base, sy, sb;
    logic [3:0] mask, fbits;
    logic [7:0] fill;
    h = m_tall ? 400 : 200;
    if (clr > 1 || dy <= -h || dy >= h || dx < -639 || dx > 639) return 1'b1;
    dxb   = dx / 8;
    po    = m_upper ? 16000 : 0;
    fbits = clr ? m_bg : 4'h0;
    if (m_mono) mask = 4'b0001 << m_mplane;
    else mask = m_four ? 4'hf : 4'h7;
    for (int pl = 0; pl < 4; pl++) begin
      if (!mask[pl]) continue;
      base = pl * PLANE_SZ;
      for (int i = 0; i < h * 80; i++)
        line_copy[i] = plane_mem[base + (po + i) % PLANE_SZ];
      fill = fbits[pl] ? 8'hff : 8'h00;
      for (int y = 0; y < h; y++) begin
        for (int b = 0; b < 80; b++) begin
          sy = y + dy;
          sb = b + dxb;
          if (sy >= 0 && sy < h && sb >= 0 && sb < 80)
            plane_mem[base + (po + y * 80 + b) % PLANE_SZ] = line_copy[sy * 80 + sb];
          else
            plane_mem[base + (po + y * 80 + b) % PLANE_SZ] = fill;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_word(logic [1:0] cmd, logic [1:0] pl, logic [14:0] addr,
                              logic [7:0] wd, logic signed [15:0] sy,
                              logic signed [15:0] sx, logic [7:0] clr);
    result_t r;
    r.read_data = 8'h00;
    r.status    = 1'b0;
    if (cmd == bsf_pkg::CMD_WRITE) begin
      if (addr < PLANE_SZ) plane_mem[pl * PLANE_SZ + addr] = wd;
    end else if (cmd == bsf_pkg::CMD_READ) begin
      if (addr < PLANE_SZ) r.read_data = plane_mem[pl * PLANE_SZ + addr];
    end else if (cmd == bsf_pkg::CMD_SCROLL) begin
      r.status = scroll_store(int'(sy), int'(sx), int'(clr));
    end
    expected_q.push_back(r);
  endtask

  // Offer one word, hold it until taken, then predict its result.
  task automatic send_word(logic [1:0] cmd, logic [1:0] pl, logic [14:0] addr,
                           logic [7:0] wd, logic signed [15:0] sy,
                           logic signed [15:0] sx, logic [7:0] clr);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_plane      <= pl;
    in_byte_addr  <= addr;
    in_write_data <= wd;
    in_shift_y    <= sy;
    in_shift_x    <= sx;
    in_clear_mode <= clr;
    do @(posedge clk); while (in_stall);
    predict_word(cmd, pl, addr, wd, sy, sx, clr);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(int unsigned idx, logic [3:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx[2:0];
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      bsf_pkg::REG_TALL:   m_tall   = val[0];
      bsf_pkg::REG_UPPER:  m_upper  = val[0];
      bsf_pkg::REG_MONO:   m_mono   = val[0];
      bsf_pkg::REG_MPLANE: m_mplane = val[1:0];
      bsf_pkg::REG_FOUR:   m_four   = val[0];
      bsf_pkg::REG_BG:     m_bg     = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic tall, logic upper, logic mono, logic [1:0] mp,
                          logic four, logic [3:0] bg);
    write_reg(bsf_pkg::REG_TALL, {3'b0, tall});
    write_reg(bsf_pkg::REG_UPPER, {3'b0, upper});
    write_reg(bsf_pkg::REG_MONO, {3'b0, mono});
    write_reg(bsf_pkg::REG_MPLANE, {2'b0, mp});
    write_reg(bsf_pkg::REG_FOUR, {3'b0, four});
    write_reg(bsf_pkg::REG_BG, bg);
  endtask

  task automatic wr(logic [1:0] pl, logic [14:0] a, logic [7:0] d);
    send_word(bsf_pkg::CMD_WRITE, pl, a, d, '0, '0, '0);
  endtask

  task automatic rd(logic [1:0] pl, logic [14:0] a);
    send_word(bsf_pkg::CMD_READ, pl, a, '0, '0, '0, '0);
  endtask

  task automatic scroll(logic signed [15:0] sy, logic signed [15:0] sx, logic [7:0] c);
    send_word(bsf_pkg::CMD_SCROLL, 2'd0, '0, '0, sy, sx, c);
  endtask

  // Check each taken result word against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        result_t e;
        e = expected_q.pop_front();
        if (out_read_data !== e.read_data) begin
          $error("read_data: expected %0h, got %0h", e.read_data, out_read_data);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0b, got %0b", e.status, out_status);
          errors++;
        end
      end
    end
  end

  // Drive the result stall; count down a long hold-off here.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Extremes of addresses and data, every command, the illegal scroll cases.
  task automatic test_directed();
    wr(2'd0, 15'd0, 8'hff);
    wr(2'd3, 15'd31999, 8'h5a);
    wr(2'd1, 15'd32000, 8'h77);   // past the plane: dropped
    wr(2'd2, 15'd32767, 8'h00);
    rd(2'd0, 15'd0);
    rd(2'd3, 15'd31999);
    rd(2'd1, 15'd32000);
    rd(2'd2, 15'd32767);
    send_word(2'd3, 2'd3, 15'h7fff, 8'hff, 16'sh7fff, 16'sh7fff, 8'hff);
    scroll(16'sd0, 16'sd0, 8'd2);
    scroll(16'sd0, 16'sd0, 8'd255);
    scroll(16'sd200, 16'sd0, 8'd0);
    scroll(-16'sd200, 16'sd0, 8'd0);
    scroll(16'sd0, 16'sd640, 8'd0);
    scroll(16'sd0, -16'sd640, 8'd1);
    scroll(-16'sd32768, -16'sd32768, 8'd0);
    scroll(16'sd32767, 16'sd32767, 8'd1);
    wait_drain();
    set_regs(1'b0, 1'b0, 1'b1, 2'd0, 1'b0, 4'hf);
    for (int i = 0; i < 8; i++) wr(2'd0, 15'(i * 81), 8'(i + 1));
    scroll(16'sd199, 16'sd639, 8'd1);
    scroll(-16'sd3, -16'sd7, 8'd0);   // -7 pixels truncates to no byte shift
    rd(2'd0, 15'd0);
    rd(2'd0, 15'd243);
    wait_drain();
  endtask

  // Walk the registers through their extremes with a legal scroll each.
  task automatic test_config_sweep();
    set_regs(1'b1, 1'b1, 1'b1, 2'd3, 1'b0, 4'ha);
    for (int i = 0; i < 6; i++) wr(2'd3, 15'($urandom_range(0, 31999)), 8'($urandom));
    scroll(-16'sd399, -16'sd639, 8'd1);
    scroll(16'sd400, 16'sd0, 8'd0);
    rd(2'd3, 15'd16000);
    wait_drain();
    set_regs(1'b0, 1'b0, 1'b0, 2'd0, 1'b1, 4'h5);
    for (int i = 0; i < 8; i++) wr(2'(i), 15'(i * 97), 8'($urandom));
    scroll(16'sd1, 16'sd8, 8'd1);
    for (int i = 0; i < 8; i++) rd(2'(i), 15'(i * 97 - 80 + 1));
    wait_drain();
    // Upper page with 200 lines ends at the last byte of the plane.
    set_regs(1'b0, 1'b1, 1'b0, 2'd2, 1'b0, 4'hf);
    wr(2'd2, 15'd31999, 8'h3c);
    wr(2'd0, 15'd16000, 8'hc3);
    scroll(-16'sd1, 16'sd15, 8'd0);
    rd(2'd2, 15'd79);
    rd(2'd0, 15'd16081);
    wait_drain();
  endtask

  task automatic random_word();
    int unsigned k, h;
    logic [14:0] a;
    k = $urandom_range(0, 199);
    h = m_tall ? 400 : 200;
    a = ($urandom_range(0, 1)) ? 15'($urandom_range(0, 255)) : 15'($urandom);
    if (k < 96) wr(2'($urandom), a, 8'($urandom));
    else if (k < 192) rd(2'($urandom), a);
    else if (k < 194) send_word(2'd3, 2'($urandom), 15'($urandom), 8'($urandom),
                                16'($urandom), 16'($urandom), 8'($urandom));
    else if (k == 199 && legal_left > 0) begin
      legal_left--;
      scroll(16'(int'($urandom_range(0, 2 * h - 2)) - int'(h - 1)),
             16'(int'($urandom_range(0, 1278)) - 639), 8'($urandom_range(0, 1)));
    end else begin
      case ($urandom_range(0, 2))
        0: scroll(16'($urandom), 16'($urandom), 8'($urandom_range(2, 255)));
        1: scroll(($urandom_range(0, 1)) ? 16'(h + $urandom_range(0, 32767 - h))
                                         : -16'(h + $urandom_range(0, 32768 - h)),
                  16'($urandom), 8'($urandom_range(0, 1)));
        default: scroll(16'sd0,
                        ($urandom_range(0, 1)) ? 16'($urandom_range(640, 32767))
                                               : -16'($urandom_range(640, 32768)),
                        8'($urandom_range(0, 1)));
      endcase
    end
  endtask

  // Four idle phases; mono mode keeps legal scrolls short.
  task automatic test_random();
    int in_pct[4]  = '{0, 73, 0, 17};
    int out_pct[4] = '{0, 0, 73, 17};
    legal_left = 4;
    for (int ph = 0; ph < 4; ph++) begin
      set_regs(1'($urandom), 1'($urandom), 1'b1, 2'($urandom), 1'($urandom),
               4'($urandom));
      send_idle_pct = in_pct[ph];
      stall_pct     = out_pct[ph];
      for (int i = 0; i < 500; i++) random_word();
      wait_drain();
    end
  endtask

  // Hold the result side off while words keep coming, so the input backs up.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off      = 300;
    for (int i = 0; i < 24; i++) begin
      if (i[0]) rd(2'($urandom), 15'($urandom_range(0, 255)));
      else wr(2'($urandom), 15'($urandom_range(0, 255)), 8'($urandom));
    end
    wait_drain();
  endtask

  initial begin
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off = 0;
    legal_left = 0;
    m_tall = 0; m_upper = 0; m_mono = 0; m_mplane = 0; m_four = 0; m_bg = 0;
    for (int i = 0; i < 4 * PLANE_SZ; i++) plane_mem[i] = 8'h00;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= '0;
    in_plane      <= '0;
    in_byte_addr  <= '0;
    in_write_data <= '0;
    in_shift_y    <= '0;
    in_shift_x    <= '0;
    in_clear_mode <= '0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_config_sweep();
    test_random();
    test_backpressure();
    wait_drain();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("** bitplane_scroll_fill: PASSED **");
    else
      $display("** bitplane_scroll_fill: FAILED **");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/bsf_pkg.sv
rtl/bsf_ctrl.sv
rtl/bsf_dpath.sv
rtl/bitplane_scroll_fill.sv
bench/tb_bitplane_scroll_fill.sv
